// File: rtl/slr_pkg.sv
// Shared types and constants for the stereo linear resampler.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package slr_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STEP_W   = 23;

  // Command kinds handed from front end to back end
  typedef enum logic {
    CMD_BYPASS,
    CMD_INTERP
  } slr_cmd_kind_e;

  // One queued command: the stored previous frame and the new frame
  typedef struct packed {
    slr_cmd_kind_e               kind;
    logic signed [SAMPLE_W-1:0]  prev_l;
    logic signed [SAMPLE_W-1:0]  prev_r;
    logic signed [SAMPLE_W-1:0]  cur_l;
    logic signed [SAMPLE_W-1:0]  cur_r;
  } slr_cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } slr_state_e;

endpackage

`default_nettype wire

// File: rtl/slr_queue.sv
// Two-entry command queue between the resampler front end and back end.
// Depends on slr_pkg for the command type.
`default_nettype none

module slr_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire slr_pkg::slr_cmd_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output slr_pkg::slr_cmd_t      pop_data_o
);
  import slr_pkg::*;

  slr_cmd_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// File: rtl/slr_front.sv
// Resampler front end: accepts input frames, keeps the previous frame and
// classifies each frame into a command. Depends on slr_pkg.
`default_nettype none

module slr_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [slr_pkg::STEP_W-1:0]     rate_step_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0] left_in_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0] right_in_i,
  output logic                                push_valid_o,
  input  wire logic                           push_ready_i,
  output slr_pkg::slr_cmd_t                   push_data_o
);
  import slr_pkg::*;

  localparam int unsigned CW = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam logic [CW-1:0] ONE_FIX = CW'(1) << FRAC_BITS;

  logic signed [SAMPLE_W-1:0] prev_l_q, prev_r_q;
  logic                       have_prev_q;
  logic                       bypass, accept;

  assign bypass     = (CW'(rate_step_i) == ONE_FIX);
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify: bypass frames always go out, the first frame is only stored
  always_comb begin
    push_valid_o       = accept && (bypass || have_prev_q);
    push_data_o.kind   = bypass ? CMD_BYPASS : CMD_INTERP;
    push_data_o.prev_l = prev_l_q;
    push_data_o.prev_r = prev_r_q;
    push_data_o.cur_l  = left_in_i;
    push_data_o.cur_r  = right_in_i;
  end

  // Hold the last accepted frame as the previous frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      have_prev_q <= 1'b0;
    end else if (accept) begin
      prev_l_q    <= left_in_i;
      prev_r_q    <= right_in_i;
      have_prev_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/slr_back.sv
// Resampler back end (depends on slr_pkg): owns the phase, steps through each
// command's output run and registers both channels, interpolated or bypassed.
`default_nettype none

module slr_back #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned MAX_RUN   = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [slr_pkg::STEP_W-1:0] rate_step_i,
  input  wire logic                       pop_valid_i,
  output logic                            pop_ready_o,
  input  wire slr_pkg::slr_cmd_t          pop_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [slr_pkg::SAMPLE_W-1:0]    left_out_o,
  output logic [slr_pkg::SAMPLE_W-1:0]    right_out_o,
  output logic                            run_end_o
);
  import slr_pkg::*;

  localparam int unsigned PW   = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam int unsigned NW   = $clog2(MAX_RUN);
  localparam int unsigned NUMW = SAMPLE_W + FRAC_BITS + 2;
  localparam logic [PW-1:0] ONE_FIX = PW'(1) << FRAC_BITS;
  localparam logic [NW-1:0] LAST_N  = NW'(MAX_RUN - 1);

  // Add the scaled previous sample and truncate the quotient toward zero
  function automatic logic [SAMPLE_W-1:0] lerp_fin(
    input logic signed [SAMPLE_W-1:0] prev,
    input logic signed [NUMW-1:0]     prod
  );
    logic signed [NUMW-1:0] num;
    logic signed [NUMW-1:0] quo;
    num = $signed({{2{prev[SAMPLE_W-1]}}, prev, {FRAC_BITS{1'b0}}}) + prod;
    quo = num >>> FRAC_BITS;
    if (num[NUMW-1] && (num[FRAC_BITS-1:0] != '0)) quo = quo + NUMW'(1);
    return quo[SAMPLE_W-1:0];
  endfunction

  slr_state_e state_q, state_d;
  slr_cmd_t   cmd_q;
  logic [PW-1:0] phase_q, p_q;
  logic [NW-1:0] n_q;
  logic          last_q;
  logic signed [NUMW-1:0] prod_l_q, prod_r_q;

  logic                      out_valid_q, out_last_q;
  logic [SAMPLE_W-1:0]       out_l_q, out_r_q;

  logic [PW-1:0]             p_nxt;
  logic                      run_last, out_free, pop, load;
  logic signed [SAMPLE_W:0]  diff_l, diff_r;
  logic signed [FRAC_BITS:0] frac;

  assign p_nxt    = p_q + PW'(rate_step_i);
  assign run_last = (p_nxt >= ONE_FIX) || (n_q == LAST_N);
  assign out_free = !out_valid_q || out_ready_i;
  assign pop      = pop_valid_i && pop_ready_o;
  assign load     = (state_q == ST_FIN) && out_free;

  assign diff_l = $signed({cmd_q.cur_l[SAMPLE_W-1], cmd_q.cur_l})
                - $signed({cmd_q.prev_l[SAMPLE_W-1], cmd_q.prev_l});
  assign diff_r = $signed({cmd_q.cur_r[SAMPLE_W-1], cmd_q.cur_r})
                - $signed({cmd_q.prev_r[SAMPLE_W-1], cmd_q.prev_r});
  assign frac   = $signed({1'b0, p_q[FRAC_BITS-1:0]});

  // Next state and queue pop
  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          if (pop_data_i.kind == CMD_BYPASS) state_d = ST_FIN;
          else if (phase_q < ONE_FIX)        state_d = ST_RUN;
        end
      end
      ST_RUN:  state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) state_d = last_q ? ST_IDLE : ST_RUN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Phase, run counter and sequencing control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      p_q     <= '0;
      n_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      if (state_q == ST_IDLE && pop) begin
        p_q    <= phase_q;
        n_q    <= '0;
        last_q <= (pop_data_i.kind == CMD_BYPASS);
        // Drop a frame that yields no output: just consume one unit of phase
        if (pop_data_i.kind == CMD_INTERP && phase_q >= ONE_FIX) begin
          phase_q <= phase_q - ONE_FIX;
        end
      end else if (state_q == ST_RUN) begin
        p_q    <= p_nxt;
        n_q    <= n_q + NW'(1);
        last_q <= run_last;
        if (run_last) phase_q <= (p_nxt >= ONE_FIX) ? (p_nxt - ONE_FIX) : '0;
      end
    end
  end

  // Capture the command and the channel products
  always_ff @(posedge clk_i) begin
    if (pop) cmd_q <= pop_data_i;
    if (state_q == ST_RUN) begin
      prod_l_q <= NUMW'(diff_l) * NUMW'(frac);
      prod_r_q <= NUMW'(diff_r) * NUMW'(frac);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_last_q <= last_q;
      if (cmd_q.kind == CMD_BYPASS) begin
        out_l_q <= cmd_q.cur_l;
        out_r_q <= cmd_q.cur_r;
      end else begin
        out_l_q <= lerp_fin(cmd_q.prev_l, prod_l_q);
        out_r_q <= lerp_fin(cmd_q.prev_r, prod_r_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;
  assign run_end_o   = out_last_q;

endmodule

`default_nettype wire

// File: rtl/stereo_linear_resampler_core.sv
// Top level of the stereo linear-interpolation resampler.
// Instantiates slr_front, slr_queue and slr_back; depends on slr_pkg.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata = {right_in, left_in}
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata = {right_out, left_out}, tlast = run_end
//   cfg       in   cfg_we_i                     cfg_wdata_i = rate_step
//
// The back end pops each command in its idle step. An interpolated output then takes a run
// step (channel multiplies) and a finish step (finish into the output register), with at most
// MAX_RUN outputs per input. A bypass frame goes from the pop straight to its finish step.
// A frame with no output is only popped. A stalled output holds the back end in its finish step;
// the two-entry queue lets the front end keep taking frames meanwhile until it fills. Reset
// clears the phase, the previous frame and the queue and sets rate_step to bypass.
`default_nettype none

module stereo_linear_resampler_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned MAX_RUN   = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [slr_pkg::STEP_W-1:0] cfg_wdata_i,   // rate_step
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [31:0]                s_axis_tdata,  // [15:0] left_in, [31:16] right_in
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // [15:0] left_out, [31:16] right_out
  output logic                            m_axis_tlast   // run_end
);
  import slr_pkg::*;

  localparam int unsigned CW = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam logic [CW-1:0] ONE_FIX = CW'(1) << FRAC_BITS;

  logic [STEP_W-1:0]   rate_step_q;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  slr_cmd_t            push_data, pop_data;
  logic [SAMPLE_W-1:0] left_out, right_out;

  // Rate step register, reset to bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       rate_step_q <= ONE_FIX[STEP_W-1:0];
    else if (cfg_we_i) rate_step_q <= cfg_wdata_i;
  end

  slr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rate_step_i  (rate_step_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .left_in_i    (s_axis_tdata[15:0]),
    .right_in_i   (s_axis_tdata[31:16]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  slr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  slr_back #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_RUN   (MAX_RUN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rate_step_i (rate_step_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .left_out_o  (left_out),
    .right_out_o (right_out),
    .run_end_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {right_out, left_out};

endmodule

`default_nettype wire

// File: tb/tb_stereo_linear_resampler_core.sv
// Self-checking testbench for stereo_linear_resampler_core: streams stereo frames under
// several rate settings and checks every output frame against an in-bench linear predictor.
// Depends on slr_pkg and the RTL of the resampler only.
`timescale 1ns / 100ps

module tb_stereo_linear_resampler_core;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned MAX_RUN      = 64;
  localparam longint      UNITY        = longint'(1) << FRAC_BITS;
  localparam int          SETTLE_WAIT  = 400;      // settle time after the last expected frame
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          REPORT_LIMIT = 10;

  // One expected output frame
  typedef struct packed {
    logic                last;
    logic signed [15:0]  right;
    logic signed [15:0]  left;
  } stereo_frame_t;

  logic                       clk_i;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [slr_pkg::STEP_W-1:0] cfg_wdata_i   = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [31:0]                s_axis_tdata  = '0;   // [15:0] left_in, [31:16] right_in
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [31:0]                m_axis_tdata;         // [15:0] left_out, [31:16] right_out
  logic                       m_axis_tlast;         // run_end

  // Predictor state
  logic [slr_pkg::STEP_W-1:0] step_cfg;
  logic [23:0]                phase_acc;
  logic signed [15:0]         last_left;
  logic signed [15:0]         last_right;
  logic                       have_last;

  stereo_frame_t expected_frames[$];
  stereo_frame_t head_frame;
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  bit            steady_flow    = 1'b0;

  stereo_linear_resampler_core #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_RUN  (MAX_RUN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the output side about a quarter of the time unless steady_flow is set
  always @(posedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 25);
  end

  // prev + (cur - prev) * frac / UNITY, truncated toward zero
  function automatic logic signed [15:0] blend_sample(input logic signed [15:0] a,
                                                       input logic signed [15:0] b,
                                                       input longint unsigned    frac);
    longint num;
    num = longint'(a) * UNITY + (longint'(b) - longint'(a)) * longint'(frac);
    return 16'(num / UNITY);
  endfunction

  // Work out the output frames caused by one accepted input frame
  task automatic predict_frames(input logic signed [15:0] cur_l, input logic signed [15:0] cur_r);
    longint unsigned p;
    int              n;
    stereo_frame_t   f;
    if (longint'(step_cfg) == UNITY) begin
      f = '{last: 1'b1, right: cur_r, left: cur_l};
      expected_frames.push_back(f);
    end else if (have_last) begin
      p = phase_acc;
      n = 0;
      while (p < UNITY && n < MAX_RUN) begin
        f.left  = blend_sample(last_left, cur_l, p);
        f.right = blend_sample(last_right, cur_r, p);
        p       = p + step_cfg;
        n++;
        f.last  = (p >= UNITY) || (n == MAX_RUN);
        expected_frames.push_back(f);
      end
      // the run limit drops what is left and clamps the phase at zero
      phase_acc = (p >= UNITY) ? 24'(p - UNITY) : '0;
    end
    last_left  = cur_l;
    last_right = cur_r;
    have_last  = 1'b1;
  endtask

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endtask

  // Compare each output transfer with the oldest expected frame
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        report_error($sformatf("unexpected frame left %0d right %0d last %0b",
                               $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                               m_axis_tlast));
      end else begin
        head_frame = expected_frames.pop_front();
        if (m_axis_tdata[15:0] !== head_frame.left)
          report_error($sformatf("left_out expected %0d, got %0d",
                                 head_frame.left, $signed(m_axis_tdata[15:0])));
        if (m_axis_tdata[31:16] !== head_frame.right)
          report_error($sformatf("right_out expected %0d, got %0d",
                                 head_frame.right, $signed(m_axis_tdata[31:16])));
        if (m_axis_tlast !== head_frame.last)
          report_error($sformatf("run_end expected %0b, got %0b", head_frame.last, m_axis_tlast));
      end
    end
  end

  // Send one frame; tvalid stays high after the transfer so back-to-back frames need no gap
  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r);
    while (!steady_flow && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frames(l, r);
  endtask

  // Drop tvalid, wait for every expected frame, then let the back end settle
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [slr_pkg::STEP_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    step_cfg     = value;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // First frame after reset is only stored
  task automatic test_first_frame();
    write_step(23'd32768);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd32767, -16'sd32768);
    send_frame(16'sd0, 16'sd0);
    drain_outputs();
  endtask

  // Unity step passes frames straight through
  task automatic test_bypass();
    write_step(23'(UNITY));
    send_frame(16'sd32767, -16'sd32768);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd0, -16'sd1);
    send_frame(-16'sd1, 16'sd0);
    drain_outputs();
  endtask

  // Full-scale swings exercise truncation toward zero on both signs
  task automatic test_full_scale();
    write_step(23'd21845);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd32767, -16'sd32768);
    send_frame(-16'sd32768, -16'sd32768);
    send_frame(16'sd32767, 16'sd32767);
    drain_outputs();
  endtask

  // Tiny and zero steps hit the run limit
  task automatic test_run_limit();
    write_step(23'd1024);
    send_frame(16'sd1000, -16'sd1000);
    send_frame(-16'sd7, 16'sd9);
    drain_outputs();
    write_step(23'd512);
    send_frame(16'sd32767, -16'sd32768);
    send_frame(-16'sd12345, 16'sd23456);
    drain_outputs();
    write_step(23'd0);
    send_frame(16'sd5, -16'sd5);
    drain_outputs();
  endtask

  // Downsampling: most frames give nothing, phase carries across frames
  task automatic test_downsample();
    write_step(23'd4194304);
    repeat (4) send_frame(pick_sample(), pick_sample());
    drain_outputs();
    write_step(23'd196608);
    repeat (6) send_frame(pick_sample(), pick_sample());
    drain_outputs();
  endtask

  // Random frame streams over a spread of rate settings
  task automatic test_random_streams();
    logic [slr_pkg::STEP_W-1:0] step;
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0:       step = 23'($urandom_range(1024, 65535));             // upsample
        1:       step = 23'($urandom_range(65537, 262144));           // mild downsample
        2:       step = 23'($urandom_range(64000, 67000));            // near unity
        3:       step = 23'(UNITY);                                   // bypass
        4:       step = 23'($urandom_range(1024, 4194304));           // anywhere in range
        default: step = 23'($urandom_range(4096, 131072));
      endcase
      write_step(step);
      steady_flow = (seg == 2);
      repeat (20) send_frame(pick_sample(), pick_sample());
      drain_outputs();
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    step_cfg   = 23'(UNITY);
    phase_acc  = '0;
    last_left  = '0;
    last_right = '0;
    have_last  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_frame();
    test_bypass();
    test_full_scale();
    test_run_limit();
    test_downsample();
    test_random_streams();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
